/* design/diode_clipper_newton_solver_unit_defines.svh */
// assertion macros shared by the diode clipper solver rtl
// no dependencies; checks compile out when SYNTHESIS is set
`ifndef DIODE_CLIPPER_NEWTON_SOLVER_UNIT_DEFINES_SVH
`define DIODE_CLIPPER_NEWTON_SOLVER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define DCN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DCN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DCN_ASSERT_IMP(lbl, ante, cons, msg)
`define DCN_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* design/dcn_pkg.sv */
// shared types, constants and the cordic angle table for the diode clipper solver
// no dependencies
package dcn_pkg;

    localparam int MAX_ITERATIONS = 50;
    localparam int SAMPLE_WIDTH   = 16;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 48;

    localparam logic [CFG_INDEX_W-1:0] REG_INPUT_GAIN   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_VT       = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_RATIO = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_GAIN  = 8'd3;

    localparam logic [23:0] INPUT_GAIN_RST   = 24'd65536;
    localparam logic [23:0] INV_VT_RST       = 24'd2534900;
    localparam logic [47:0] CUR_RATIO_RST    = 48'd562949;
    localparam logic [23:0] OUTPUT_GAIN_RST  = 24'd65536;

    localparam logic [23:0] STEP_MAX    = 24'd13421773;
    localparam logic [27:0] LN2_Q28     = 28'd186065280;
    localparam logic [33:0] ARG_MAX     = 34'd12884901888;
    localparam logic [38:0] TERM_LIMIT  = 39'd274877906944;
    localparam logic [30:0] CORDIC_INIT = 31'd1296540104;

    localparam int CORDIC_STEPS = 32;
    localparam int DIV_STEPS    = 28;
    localparam int RED_BITS     = 7;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ARG,
        OP_RED,
        OP_CINIT,
        OP_CSTEP,
        OP_MUL,
        OP_SHIFT,
        OP_SLOPE,
        OP_RESID,
        OP_DSTEP,
        OP_UPDATE,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] idx;
    } cmd_t;

    typedef struct packed {
        logic step_zero;
    } status_t;

    // atanh(2^-i) in q.30, exact powers of two past stage nine
    function automatic logic [30:0] atanh_q30(input logic [4:0] i);
        logic [30:0] r;
        case (i)
            5'd1:    r = 31'd589812981;
            5'd2:    r = 31'd274247418;
            5'd3:    r = 31'd134923406;
            5'd4:    r = 31'd67196451;
            5'd5:    r = 31'd33565361;
            5'd6:    r = 31'd16778582;
            5'd7:    r = 31'd8388779;
            5'd8:    r = 31'd4194325;
            5'd9:    r = 31'd2097155;
            default: r = 31'd1 << (5'd30 - i);
        endcase
        return r;
    endfunction

endpackage

/* design/dcn_ifs.sv */
// valid/ready stream interfaces for the sample input and result channels
// depends on dcn_pkg for the default sample width
interface dcn_in_if #(
    parameter int SAMPLE_WIDTH = dcn_pkg::SAMPLE_WIDTH
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface dcn_out_if #(
    parameter int SAMPLE_WIDTH = dcn_pkg::SAMPLE_WIDTH
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           saturated;
    logic                           converged;

    modport source (output valid, output sample_out, output saturated, output converged,
                    input ready);
    modport sink   (input valid, input sample_out, input saturated, input converged,
                    output ready);
endinterface

/* design/dcn_datapath.sv */
// newton datapath: argument scaling, range reduction, cordic, diode term, divider, update
// depends on dcn_pkg; driven by dcn_controller through cmd_t
module dcn_datapath #(
    parameter int SAMPLE_WIDTH = dcn_pkg::SAMPLE_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dcn_pkg::cmd_t                  cmd,
    output dcn_pkg::status_t               status,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic [23:0]                    input_gain,
    input  logic [23:0]                    inv_thermal_voltage,
    input  logic [47:0]                    diode_current_ratio,
    input  logic [23:0]                    output_gain,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic                           saturated,
    output logic                           converged
);

    localparam int VIN_SHR = (SAMPLE_WIDTH >= 13) ? SAMPLE_WIDTH - 13 : 0;
    localparam int VIN_SHL = (SAMPLE_WIDTH < 13) ? 13 - SAMPLE_WIDTH : 0;
    localparam int OUT_SHR = 45 - SAMPLE_WIDTH;
    localparam logic signed [56:0] Y_HI = 57'sd1 <<< (SAMPLE_WIDTH - 1);

    logic signed [37:0] vin_reg, vin_next;
    logic signed [31:0] v_reg, v_next;
    logic [33:0]        ax_reg, ax_next;
    logic [6:0]         k_reg, k_next;
    logic signed [33:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [31:0] z_reg, z_next;
    logic [80:0]        acc_reg, acc_next;
    logic [38:0]        p_reg, p_next, m_reg, m_next;
    logic [47:0]        g_reg, g_next;
    logic signed [39:0] d_reg, d_next;
    logic [49:0]        rem_reg, rem_next;
    logic [48:0]        den_reg, den_next;
    logic [27:0]        q_reg, q_next;
    logic               big_reg, big_next;
    logic               conv_reg, conv_next;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg, out_sample_next;
    logic               out_sat_reg, out_sat_next;
    logic               out_conv_reg, out_conv_next;

    logic [23:0] step;
    logic        step_zero;

    always_comb
    begin
        if (big_reg || q_reg > 28'(STEP_MAX_W()))
        begin
            step = dcn_pkg::STEP_MAX;
        end
        else
        begin
            step = q_reg[23:0];
        end
        step_zero = (step == 24'd0);
    end

    function automatic logic [27:0] STEP_MAX_W();
        return 28'(dcn_pkg::STEP_MAX);
    endfunction

    assign status.step_zero = step_zero;

    always_comb
    begin
        logic signed [63:0] prod_in;
        logic signed [63:0] vin_full;
        logic [31:0]        av;
        logic [55:0]        arg_prod;
        logic [34:0]        red_sub;
        logic signed [33:0] tx, ty;
        logic signed [31:0] ang;
        logic signed [34:0] usum;
        logic [32:0]        uc;
        logic [23:0]        half;
        logic [56:0]        pp;
        logic [7:0]         amt;
        logic [98:0]        wide;
        logic [38:0]        term;
        logic [38:0]        shv;
        logic [39:0]        ch;
        logic [63:0]        gprod;
        logic signed [41:0] f;
        logic [41:0]        af;
        logic [49:0]        r2;
        logic signed [32:0] vw;
        logic signed [56:0] y;
        logic signed [56:0] ysh;

        vin_next        = vin_reg;
        v_next          = v_reg;
        ax_next         = ax_reg;
        k_next          = k_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        z_next          = z_reg;
        acc_next        = acc_reg;
        p_next          = p_reg;
        m_next          = m_reg;
        g_next          = g_reg;
        d_next          = d_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        q_next          = q_reg;
        big_next        = big_reg;
        conv_next       = conv_reg;
        out_sample_next = out_sample_reg;
        out_sat_next    = out_sat_reg;
        out_conv_next   = out_conv_reg;

        prod_in  = 64'(sample_in) * 64'($signed({1'b0, input_gain}));
        vin_full = (prod_in >>> VIN_SHR) <<< VIN_SHL;
        av       = v_reg[31] ? 32'(-v_reg) : 32'(v_reg);
        arg_prod = 56'(av) * 56'(inv_thermal_voltage);
        red_sub  = 35'(dcn_pkg::LN2_Q28) << cmd.idx[2:0];
        tx       = cy_reg >>> cmd.idx;
        ty       = cx_reg >>> cmd.idx;
        ang      = $signed({1'b0, dcn_pkg::atanh_q30(cmd.idx)});
        usum     = cmd.idx[1] ? 35'(cx_reg) - 35'(cy_reg) : 35'(cx_reg) + 35'(cy_reg);
        uc       = (usum > 35'sd0) ? usum[32:0] : 33'd0;
        half     = cmd.idx[0] ? diode_current_ratio[47:24] : diode_current_ratio[23:0];
        pp       = 57'(uc) * 57'(half);
        amt      = cmd.idx[0] ? 8'd69 + 8'(k_reg) : 8'd69 - 8'(k_reg);
        wide     = {acc_reg, 18'd0} >> amt;
        term     = (wide > 99'(dcn_pkg::TERM_LIMIT)) ? dcn_pkg::TERM_LIMIT : wide[38:0];
        shv      = (p_reg > m_reg) ? p_reg - m_reg : 39'd0;
        ch       = 40'(p_reg) + 40'(m_reg);
        gprod    = 64'(ch) * 64'(inv_thermal_voltage);
        f        = 42'(vin_reg) - 42'(v_reg) - 42'(d_reg);
        af       = f[41] ? 42'(-f) : 42'(f);
        r2       = {rem_reg[48:0], 1'b0};
        vw       = 33'(v_reg);
        y        = 57'(v_reg) * 57'($signed({1'b0, output_gain}));
        ysh      = y >>> OUT_SHR;

        case (cmd.op)
            dcn_pkg::OP_LOAD:
            begin
                vin_next = vin_full[37:0];
            end
            dcn_pkg::OP_ARG:
            begin
                ax_next = (arg_prod[55:16] > 40'(dcn_pkg::ARG_MAX)) ? dcn_pkg::ARG_MAX
                                                                    : arg_prod[49:16];
                k_next  = '0;
            end
            dcn_pkg::OP_RED:
            begin
                if ({1'b0, ax_reg} >= red_sub)
                begin
                    ax_next                = 34'({1'b0, ax_reg} - red_sub);
                    k_next[cmd.idx[2:0]]   = 1'b1;
                end
            end
            dcn_pkg::OP_CINIT:
            begin
                cx_next = 34'(dcn_pkg::CORDIC_INIT);
                cy_next = '0;
                z_next  = $signed({2'b00, ax_reg[27:0], 2'b00});
            end
            dcn_pkg::OP_CSTEP:
            begin
                if (!z_reg[31])
                begin
                    cx_next = cx_reg + tx;
                    cy_next = cy_reg + ty;
                    z_next  = z_reg - ang;
                end
                else
                begin
                    cx_next = cx_reg - tx;
                    cy_next = cy_reg - ty;
                    z_next  = z_reg + ang;
                end
            end
            dcn_pkg::OP_MUL:
            begin
                // low half starts the product, high half adds in at 24 bits up
                acc_next = cmd.idx[0] ? acc_reg + (81'(pp) << 24) : 81'(pp);
            end
            dcn_pkg::OP_SHIFT:
            begin
                if (cmd.idx[0])
                begin
                    m_next = term;
                end
                else
                begin
                    p_next = term;
                end
            end
            dcn_pkg::OP_SLOPE:
            begin
                g_next = gprod[63:16];
                d_next = v_reg[31] ? -$signed({1'b0, shv}) : $signed({1'b0, shv});
            end
            dcn_pkg::OP_RESID:
            begin
                rem_next = 50'(af);
                den_next = 49'(1 << 28) + 49'(g_reg);
                big_next = (49'(af) >= 49'(1 << 28) + 49'(g_reg));
                q_next   = '0;
                d_next   = $signed({39'd0, f[41]});
            end
            dcn_pkg::OP_DSTEP:
            begin
                if (r2 >= {1'b0, den_reg})
                begin
                    rem_next = r2 - {1'b0, den_reg};
                    q_next   = {q_reg[26:0], 1'b1};
                end
                else
                begin
                    rem_next = r2;
                    q_next   = {q_reg[26:0], 1'b0};
                end
            end
            dcn_pkg::OP_UPDATE:
            begin
                conv_next = step_zero;
                if (!step_zero)
                begin
                    // sign of the residual was parked in the low bit of d
                    vw = d_reg[0] ? 33'(v_reg) - 33'(step) : 33'(v_reg) + 33'(step);
                    if (vw > 33'sd2147483647)
                    begin
                        v_next = 32'sh7fffffff;
                    end
                    else if (vw < -33'sd2147483648)
                    begin
                        v_next = 32'sh80000000;
                    end
                    else
                    begin
                        v_next = vw[31:0];
                    end
                end
            end
            dcn_pkg::OP_FINISH:
            begin
                out_conv_next = conv_reg;
                if (ysh > Y_HI - 57'sd1)
                begin
                    out_sample_next = (SAMPLE_WIDTH)'(Y_HI - 57'sd1);
                    out_sat_next    = 1'b1;
                end
                else if (ysh < -Y_HI)
                begin
                    out_sample_next = (SAMPLE_WIDTH)'(-Y_HI);
                    out_sat_next    = 1'b1;
                end
                else
                begin
                    out_sample_next = ysh[SAMPLE_WIDTH-1:0];
                    out_sat_next    = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vin_reg        <= vin_next;
        ax_reg         <= ax_next;
        k_reg          <= k_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        z_reg          <= z_next;
        acc_reg        <= acc_next;
        p_reg          <= p_next;
        m_reg          <= m_next;
        g_reg          <= g_next;
        d_reg          <= d_next;
        rem_reg        <= rem_next;
        den_reg        <= den_next;
        q_reg          <= q_next;
        big_reg        <= big_next;
        conv_reg       <= conv_next;
        out_sample_reg <= out_sample_next;
        out_sat_reg    <= out_sat_next;
        out_conv_reg   <= out_conv_next;
    end

    assign sample_out = out_sample_reg;
    assign saturated  = out_sat_reg;
    assign converged  = out_conv_reg;

endmodule

/* design/dcn_controller.sv */
// sequencer for the newton loop: steps the datapath through each iteration phase
// depends on dcn_pkg and the assertion macro header
`include "diode_clipper_newton_solver_unit_defines.svh"

module dcn_controller #(
    parameter int MAX_ITERATIONS = dcn_pkg::MAX_ITERATIONS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output dcn_pkg::cmd_t    cmd,
    input  dcn_pkg::status_t status
);

    localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_ARG    = 11'b00000000010,
        S_RED    = 11'b00000000100,
        S_CINIT  = 11'b00000001000,
        S_CORDIC = 11'b00000010000,
        S_PROD   = 11'b00000100000,
        S_SLOPE  = 11'b00001000000,
        S_RESID  = 11'b00010000000,
        S_DIV    = 11'b00100000000,
        S_UPDATE = 11'b01000000000,
        S_FINISH = 11'b10000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic                out_valid_reg, out_valid_next;
    logic [4:0]          stage;

    // stages four and thirteen run twice
    always_comb
    begin
        if (cnt_reg < 5'd4)
        begin
            stage = cnt_reg + 5'd1;
        end
        else if (cnt_reg <= 5'd13)
        begin
            stage = cnt_reg;
        end
        else
        begin
            stage = cnt_reg - 5'd1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = dcn_pkg::OP_NONE;
        cmd.idx        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = dcn_pkg::OP_LOAD;
                    iter_next  = '0;
                    state_next = S_ARG;
                end
            end
            S_ARG:
            begin
                cmd.op     = dcn_pkg::OP_ARG;
                cnt_next   = 5'(dcn_pkg::RED_BITS - 1);
                state_next = S_RED;
            end
            S_RED:
            begin
                cmd.op  = dcn_pkg::OP_RED;
                cmd.idx = cnt_reg;
                if (cnt_reg == 5'd0)
                begin
                    state_next = S_CINIT;
                end
                else
                begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            S_CINIT:
            begin
                cmd.op     = dcn_pkg::OP_CINIT;
                cnt_next   = '0;
                state_next = S_CORDIC;
            end
            S_CORDIC:
            begin
                cmd.op  = dcn_pkg::OP_CSTEP;
                cmd.idx = stage;
                if (cnt_reg == 5'(dcn_pkg::CORDIC_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_PROD;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_PROD:
            begin
                // two partial products then a scale for e^+r, same again for e^-r
                case (cnt_reg)
                    5'd0:
                    begin
                        cmd.op  = dcn_pkg::OP_MUL;
                        cmd.idx = 5'b00000;
                    end
                    5'd1:
                    begin
                        cmd.op  = dcn_pkg::OP_MUL;
                        cmd.idx = 5'b00001;
                    end
                    5'd2:
                    begin
                        cmd.op  = dcn_pkg::OP_SHIFT;
                        cmd.idx = 5'b00000;
                    end
                    5'd3:
                    begin
                        cmd.op  = dcn_pkg::OP_MUL;
                        cmd.idx = 5'b00010;
                    end
                    5'd4:
                    begin
                        cmd.op  = dcn_pkg::OP_MUL;
                        cmd.idx = 5'b00011;
                    end
                    default:
                    begin
                        cmd.op  = dcn_pkg::OP_SHIFT;
                        cmd.idx = 5'b00001;
                    end
                endcase
                if (cnt_reg == 5'd5)
                begin
                    state_next = S_SLOPE;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_SLOPE:
            begin
                cmd.op     = dcn_pkg::OP_SLOPE;
                state_next = S_RESID;
            end
            S_RESID:
            begin
                cmd.op     = dcn_pkg::OP_RESID;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = dcn_pkg::OP_DSTEP;
                if (cnt_reg == 5'(dcn_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_UPDATE:
            begin
                cmd.op = dcn_pkg::OP_UPDATE;
                if (status.step_zero || iter_reg == ITER_W'(MAX_ITERATIONS - 1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    iter_next  = iter_reg + 1'b1;
                    state_next = S_ARG;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = dcn_pkg::OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `DCN_ASSERT_IMP(a_iter_bound, 1'b1, iter_reg < ITER_W'(MAX_ITERATIONS), "iteration overrun")
    `DCN_ASSERT_NXT(a_accept_starts, in_valid && in_ready, state_reg == S_ARG, "accept lost")
    `DCN_ASSERT_NXT(a_finish_shows, cmd.op == dcn_pkg::OP_FINISH, out_valid_reg, "result dropped")

endmodule

/* design/diode_clipper_newton_solver_unit.sv */
// antiparallel diode clipper solver: one sample in, one clipped sample out
// each sample runs N newton iterations (1..MAX_ITERATIONS) from accept to result
// one sample at a time: a new sample is accepted only after the previous result is issued
// the iteration count and the 32-step cordic and 28-step divide per iteration set the rate
// a result held by the receiver stalls the next result, not the next accept
// async active-low reset clears control, node voltage and the registers to defaults
module diode_clipper_newton_solver_unit #(
    parameter int MAX_ITERATIONS = dcn_pkg::MAX_ITERATIONS,
    parameter int SAMPLE_WIDTH   = dcn_pkg::SAMPLE_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [dcn_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dcn_pkg::CFG_DATA_W-1:0]     cfg_data,
    dcn_in_if.sink                             in_ch,
    dcn_out_if.source                          out_ch
);

    logic [23:0] input_gain_reg, inv_vt_reg, output_gain_reg;
    logic [47:0] ratio_reg;

    dcn_pkg::cmd_t    cmd;
    dcn_pkg::status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_gain_reg  <= dcn_pkg::INPUT_GAIN_RST;
            inv_vt_reg      <= dcn_pkg::INV_VT_RST;
            ratio_reg       <= dcn_pkg::CUR_RATIO_RST;
            output_gain_reg <= dcn_pkg::OUTPUT_GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dcn_pkg::REG_INPUT_GAIN:    input_gain_reg  <= cfg_data[23:0];
                dcn_pkg::REG_INV_VT:        inv_vt_reg      <= cfg_data[23:0];
                dcn_pkg::REG_CURRENT_RATIO: ratio_reg       <= cfg_data[47:0];
                dcn_pkg::REG_OUTPUT_GAIN:   output_gain_reg <= cfg_data[23:0];
                default:
                begin
                end
            endcase
        end
    end

    dcn_controller #(
        .MAX_ITERATIONS(MAX_ITERATIONS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    dcn_datapath #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .sample_in           (in_ch.sample_in),
        .input_gain          (input_gain_reg),
        .inv_thermal_voltage (inv_vt_reg),
        .diode_current_ratio (ratio_reg),
        .output_gain         (output_gain_reg),
        .sample_out          (out_ch.sample_out),
        .saturated           (out_ch.saturated),
        .converged           (out_ch.converged)
    );

endmodule

/* tb/sv/diode_clipper_newton_solver_unit_checker.sv */
`timescale 1ns / 1ps
// result checker for the diode clipper solver: watches config writes and both streams
// depends on dcn_pkg and the stream interfaces in dcn_ifs.sv
module diode_clipper_newton_solver_unit_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dcn_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dcn_pkg::CFG_DATA_W-1:0]  cfg_data,
    dcn_in_if                               in_ch,
    dcn_out_if                              out_ch,
    output int                              fail_count,
    output int                              pending
);
    import dcn_pkg::*;

    typedef struct {
        logic signed [15:0] sample_out;
        logic               saturated;
        logic               converged;
    } clip_result_t;

    localparam longint ANGLES [9] = '{589812981, 274247418, 134923406, 67196451,
                                      33565361, 16778582, 8388779, 4194325, 2097155};
    localparam longint unsigned LIMIT_LSB = 64'd274877906944;

    logic [23:0]        in_gain, inv_vt, out_gain;
    logic [47:0]        cur_ratio;
    logic signed [31:0] node_v;
    clip_result_t       expected_q [$];

    // floor(a*b*2^-s) clipped to the diode term limit
    function automatic longint unsigned sat_scale(input longint unsigned a, b, input int s);
        logic [127:0] prod, r;
        prod = {64'd0, a} * {64'd0, b};
        if (s >= 128)
            return 0;
        // a negative shift scales up
        r = (s < 0) ? prod << (-s) : prod >> s;
        return (r > LIMIT_LSB) ? LIMIT_LSB : r[63:0];
    endfunction

    function automatic void diode_term(input longint v, output longint d,
                                       output longint unsigned g);
        longint unsigned av, ax, kred, p, m, shv, chv;
        longint cx, cy, z, ang, tx, ty;
        int reps;
        logic [127:0] gw;
        av = (v < 0) ? -v : v;
        ax = (av * inv_vt) >> 16;
        if (ax > ARG_MAX)
            ax = ARG_MAX;
        kred = ax / LN2_Q28;
        z = longint'((ax - kred * LN2_Q28) << 2);
        cx = CORDIC_INIT;
        cy = 0;
        for (int i = 1; i <= 30; i++)
        begin
            ang = (i <= 9) ? ANGLES[i-1] : (64'sd1 <<< (30 - i));
            reps = (i == 4 || i == 13) ? 2 : 1;
            for (int r = 0; r < reps; r++)
            begin
                tx = cy >>> i;
                ty = cx >>> i;
                if (z >= 0)
                begin
                    cx += tx; cy += ty; z -= ang;
                end
                else
                begin
                    cx -= tx; cy -= ty; z += ang;
                end
            end
        end
        p = sat_scale(cur_ratio, (cx + cy > 0) ? cx + cy : 0, 51 - int'(kred));
        m = sat_scale(cur_ratio, (cx - cy > 0) ? cx - cy : 0, 51 + int'(kred));
        shv = (p > m) ? p - m : 0;
        chv = p + m;
        gw = ({64'd0, chv} * inv_vt) >> 16;
        g = gw[63:0];
        d = (v < 0) ? -longint'(shv) : longint'(shv);
    endfunction

    function automatic clip_result_t solve_sample(input logic signed [15:0] smp);
        clip_result_t res;
        longint vin, v, d, f, y;
        longint unsigned g, af, den, stp;
        res.converged = 0;
        res.saturated = 0;
        vin = (longint'(smp) * longint'(in_gain)) >>> 3;
        v = node_v;
        for (int it = 0; it < MAX_ITERATIONS; it++)
        begin
            diode_term(v, d, g);
            f = vin - v - d;
            af = (f < 0) ? -f : f;
            den = (64'd1 << 28) + g;
            if (af >= den)
                stp = STEP_MAX;
            else
            begin
                stp = 0;
                for (int b = 0; b < 28; b++)
                begin
                    af = af << 1;
                    stp = stp << 1;
                    if (af >= den)
                    begin
                        af -= den;
                        stp |= 1;
                    end
                end
                if (stp > STEP_MAX)
                    stp = STEP_MAX;
            end
            if (stp == 0)
            begin
                res.converged = 1;
                break;
            end
            v += (f < 0) ? -longint'(stp) : longint'(stp);
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            if (v < -64'sd2147483648)
                v = -64'sd2147483648;
        end
        node_v = v[31:0];
        y = (v * longint'(out_gain)) >>> 29;
        if (y > 32767)
        begin
            y = 32767; res.saturated = 1;
        end
        if (y < -32768)
        begin
            y = -32768; res.saturated = 1;
        end
        res.sample_out = y[15:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        clip_result_t got, want;
        if (!rst_n)
        begin
            in_gain    = INPUT_GAIN_RST;
            inv_vt     = INV_VT_RST;
            cur_ratio  = CUR_RATIO_RST;
            out_gain   = OUTPUT_GAIN_RST;
            node_v     = 0;
            fail_count = 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_INPUT_GAIN:    in_gain   = cfg_data[23:0];
                    REG_INV_VT:        inv_vt    = cfg_data[23:0];
                    REG_CURRENT_RATIO: cur_ratio = cfg_data[47:0];
                    REG_OUTPUT_GAIN:   out_gain  = cfg_data[23:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                expected_q.push_back(solve_sample(in_ch.sample_in));
            if (out_ch.valid && out_ch.ready)
            begin
                got.sample_out = out_ch.sample_out;
                got.saturated  = out_ch.saturated;
                got.converged  = out_ch.converged;
                if (expected_q.size() == 0)
                begin
                    $error("result beat with nothing expected: sample_out %0d", got.sample_out);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.sample_out !== want.sample_out)
                    begin
                        $error("sample_out expected %0d actual %0d",
                               want.sample_out, got.sample_out);
                        fail_count++;
                    end
                    if (got.saturated !== want.saturated)
                    begin
                        $error("saturated expected %0b actual %0b",
                               want.saturated, got.saturated);
                        fail_count++;
                    end
                    if (got.converged !== want.converged)
                    begin
                        $error("converged expected %0b actual %0b",
                               want.converged, got.converged);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

/* tb/sv/diode_clipper_newton_solver_unit_tb.sv */
`timescale 1ns / 1ps
// top of the diode clipper solver testbench: clock, reset, config writes and sample stimulus
// depends on dcn_pkg, dcn_ifs.sv, the solver rtl and diode_clipper_newton_solver_unit_checker
module diode_clipper_newton_solver_unit_tb;
    import dcn_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     fail_count;
    int                     pending;
    int                     samples_sent;
    int                     settings_used;
    bit                     hold_req;

    dcn_in_if  in_ch ();
    dcn_out_if out_ch ();

    diode_clipper_newton_solver_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    diode_clipper_newton_solver_unit_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("diode_clipper_newton_solver_unit regression: fail");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 13) return 0;
        if (r < 18) return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    // receiver: random ready, with one long hold-off on request
    initial
    begin
        int hold_left;
        int gap;
        hold_left = 0;
        gap = 0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_left = 12000;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (gap > 0)
            begin
                gap--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                gap = pick_gap();
                out_ch.ready <= (gap == 0) || ($urandom_range(0, 1) == 1);
            end
        end
    end

    // stop offering, let the last beat register, then wait for all results; ends on a clock edge
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    task automatic load_setting(input logic [23:0] ig, input logic [23:0] ivt,
                                input logic [47:0] kr, input logic [23:0] og);
        wait_idle();
        write_reg(REG_INPUT_GAIN, {24'($urandom), ig});
        write_reg(REG_INV_VT, {24'h0, ivt});
        write_reg(REG_CURRENT_RATIO, kr);
        write_reg(REG_OUTPUT_GAIN, {24'($urandom), og});
        // an unused index must leave every register alone
        write_reg(CFG_INDEX_W'($urandom_range(4, 255)), 48'({$urandom, $urandom}));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_sample(input logic signed [15:0] s);
        int gap;
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= s;
        do @(posedge clk); while (!in_ch.ready);
        samples_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [15:0] rand_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
        if (r < 4) return 16'($signed($urandom_range(0, 2047)) - 1024);
        return 16'($urandom);
    endfunction

    function automatic logic [23:0] near24(input logic [23:0] base);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 24'($urandom);
        return base + 24'($urandom_range(0, base)) - 24'(base >> 1);
    endfunction

    initial
    begin
        logic signed [15:0] directed [12];
        directed = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff, 16'sh7fff,
                     16'sh7fff, 16'sh8000, 16'sh0400, 16'shfc00, 16'sh5555, 16'shaaaa};
        samples_sent  = 0;
        settings_used = 0;
        hold_req      = 0;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.sample_in <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values first, then the extremes of every register
        foreach (directed[i]) send_sample(directed[i]);
        load_setting(24'd65536, 24'd2534900, 48'd0, 24'd65536);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh1234);
        load_setting(24'hffffff, 24'hffffff, 48'hffffffffffff, 24'hffffff);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh0001);
        load_setting(24'd0, 24'd0, 48'd562949, 24'd0);
        send_sample(16'sh7fff);
        send_sample(16'shffff);
        load_setting(24'hffffff, 24'd2534900, 48'd1, 24'hffffff);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);

        // random settings around realistic values, a few fully random
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase % 3 == 2)
                load_setting(24'($urandom), 24'($urandom), 48'({$urandom, $urandom}),
                             24'($urandom));
            else
                load_setting(near24(24'd65536), near24(24'd2534900),
                             48'($urandom_range(1, 2000000)), near24(24'd65536));
            if (phase == 3)
                hold_req = 1;
            for (int n = 0; n < 25; n++)
            begin
                send_sample(rand_sample());
                if (phase == 5 && n == 12)
                begin
                    wait_idle();
                end
            end
        end

        wait_idle();
        repeat (4000) @(posedge clk);
        $display("solved %0d samples under %0d register settings, including register extremes",
                 samples_sent, settings_used);
        $display("and a long result hold-off with the input held back");
        if (fail_count == 0 && pending == 0)
            $display("diode_clipper_newton_solver_unit regression: pass");
        else
            $display("diode_clipper_newton_solver_unit regression: fail");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/dcn_pkg.sv
design/dcn_ifs.sv
design/dcn_datapath.sv
design/dcn_controller.sv
design/diode_clipper_newton_solver_unit.sv
tb/sv/diode_clipper_newton_solver_unit_checker.sv
tb/sv/diode_clipper_newton_solver_unit_tb.sv
